// File: rtl/core/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the cooperative task scheduler
// Request codes, dispatch codes, widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MaxTasks = 64;
  localparam int MaxSlots = 8;
  localparam int TidW     = 6;
  localparam int SlotW    = 3;

  typedef logic [TidW-1:0]     tid_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [MaxTasks-1:0] tmap_t;
  typedef logic [MaxSlots-1:0] smap_t;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_QUEUE  = 3'd2,
    REQ_WAIT   = 3'd3,
    REQ_FINISH = 3'd4,
    REQ_SIGNAL = 3'd5,
    REQ_SCHED  = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    DISP_IDLE   = 2'd0,
    DISP_RESUME = 2'd1,
    DISP_START  = 2'd2
  } disp_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;   // perform request bookkeeping
    logic sched;  // commit scheduler decision
  } cts_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic run_sched; // the request wants the scheduler
  } cts_sts_t;

endpackage

// File: rtl/core/cts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_ctrl: request sequencer
// Steps each item through execute, optional schedule and result strobe.
// ----------------------------------------------------------------------------
module cts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cts_pkg::cts_sts_t sts,
  output cts_pkg::cts_cmd_t cmd,
  output logic              out_valid
);
  import cts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCHED} state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.run_sched) begin
          state_nxt = S_SCHED;
        end else begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_SCHED: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.sched = (state_r == S_SCHED);
  assign out_valid = valid_r;

endmodule

// File: rtl/core/cts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_dp: scheduler datapath
// Task bitmaps, slot state and the rotating priority searches.
// ----------------------------------------------------------------------------
module cts_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        in_req_type,
  input  logic [5:0]        in_task_id,
  input  logic [2:0]        in_slot_index,
  input  cts_pkg::cts_cmd_t cmd,
  output cts_pkg::cts_sts_t sts,
  output logic              out_ok,
  output logic [5:0]        out_new_task_id,
  output logic [1:0]        out_dispatch,
  output logic [2:0]        out_dispatch_slot,
  output logic [5:0]        out_running_task,
  output logic              out_running_valid
);
  import cts_pkg::*;

  tmap_t used_r, queued_r, active_r;
  tid_t  highest_r, last_task_r;
  slot_t last_slot_r, cur_slot_r;
  logic  cur_valid_r;
  smap_t parked_r, armed_r, ready_r;
  tid_t  slot_task_r [MaxSlots];

  req_t  req_r;
  tid_t  tid_r;
  slot_t sidx_r;
  logic  ok_r;
  tid_t  new_id_r;
  disp_t disp_r;
  slot_t dslot_r;

  // Lowest free id and highest used id after delete
  tid_t  free_id;
  logic  free_any;
  tmap_t used_del;
  tid_t  high_del;
  always_comb begin
    free_id  = '0;
    free_any = 1'b0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_id  = tid_t'(i);
        free_any = 1'b1;
      end
    end
    used_del          = used_r;
    used_del[tid_r]   = 1'b0;
    high_del          = '0;
    for (int i = 0; i < MaxTasks; i++) begin
      if (used_del[i]) high_del = tid_t'(i);
    end
  end

  // Slot search: first armed+ready after last pick, last free slot in order
  logic  res_any, free_slot_any;
  slot_t res_slot, free_slot;
  always_comb begin
    slot_t s;
    res_any       = 1'b0;
    res_slot      = '0;
    free_slot_any = 1'b0;
    free_slot     = '0;
    s             = last_slot_r;
    for (int k = 0; k < MaxSlots; k++) begin
      s = (s == slot_t'(MaxSlots - 1)) ? '0 : slot_t'(s + 1'b1);
      if (parked_r[s]) begin
        if (armed_r[s] && ready_r[s] && !res_any) begin
          res_any  = 1'b1;
          res_slot = s;
        end
      end else begin
        free_slot     = s;
        free_slot_any = 1'b1;
      end
    end
  end

  // Task search: rotate eligible map so the scan starts after last pick
  tmap_t elig, rot;
  logic  task_any;
  tid_t  task_pick;
  always_comb begin
    tid_t off;
    for (int i = 0; i < MaxTasks; i++) begin
      elig[i] = used_r[i] && queued_r[i] && !active_r[i] &&
                (tid_t'(i) <= highest_r);
    end
    off = (last_task_r >= highest_r) ? '0 : tid_t'(last_task_r + 1'b1);
    rot = (elig >> off) | (elig << (7'(MaxTasks) - {1'b0, off}));
    task_any  = 1'b0;
    task_pick = '0;
    for (int i = MaxTasks - 1; i >= 0; i--) begin
      if (rot[i]) begin
        task_any  = 1'b1;
        task_pick = tid_t'(off + tid_t'(i));
      end
    end
  end

  // Flag requests that go on to the scheduler while they execute
  assign sts.run_sched = (((req_r == REQ_WAIT) || (req_r == REQ_FINISH)) && cur_valid_r) ||
                         ((req_r == REQ_SCHED) && !cur_valid_r);

  // Request bookkeeping and scheduler commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      queued_r    <= '0;
      active_r    <= '0;
      highest_r   <= '0;
      last_task_r <= '0;
      last_slot_r <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      parked_r    <= '0;
      armed_r     <= '0;
      ready_r     <= '0;
      for (int i = 0; i < MaxSlots; i++) slot_task_r[i] <= '0;
    end else if (start && !busy) begin
      // latch item
      req_r    <= req_t'(in_req_type);
      tid_r    <= in_task_id;
      sidx_r   <= in_slot_index;
      ok_r     <= 1'b0;
      new_id_r <= '0;
      disp_r   <= DISP_IDLE;
      dslot_r  <= '0;
    end else if (cmd.exec) begin
      unique case (req_r)
        REQ_ADD: begin
          if (free_any) begin
            used_r[free_id]   <= 1'b1;
            active_r[free_id] <= 1'b0;
            queued_r[free_id] <= 1'b0;
            if (highest_r < free_id) highest_r <= free_id;
            ok_r     <= 1'b1;
            new_id_r <= free_id;
          end
        end
        REQ_DELETE: begin
          used_r    <= used_del;
          highest_r <= high_del;
          ok_r      <= 1'b1;
        end
        REQ_QUEUE: begin
          if (used_r[tid_r]) begin
            queued_r[tid_r] <= 1'b1;
            ok_r            <= 1'b1;
          end
        end
        REQ_WAIT: begin
          if (cur_valid_r) begin
            armed_r[cur_slot_r] <= 1'b1;
            ready_r[cur_slot_r] <= 1'b0;
            cur_valid_r         <= 1'b0;
            ok_r                <= 1'b1;
          end
        end
        REQ_FINISH: begin
          if (cur_valid_r) begin
            active_r[slot_task_r[cur_slot_r]] <= 1'b0;
            parked_r[cur_slot_r] <= 1'b0;
            armed_r[cur_slot_r]  <= 1'b0;
            ready_r[cur_slot_r]  <= 1'b0;
            cur_valid_r          <= 1'b0;
            ok_r                 <= 1'b1;
          end
        end
        REQ_SIGNAL: begin
          if (parked_r[sidx_r] && armed_r[sidx_r]) begin
            ready_r[sidx_r] <= 1'b1;
            ok_r            <= 1'b1;
          end
        end
        REQ_SCHED: begin
          if (!cur_valid_r) begin
            ok_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.sched) begin
      if (res_any) begin
        armed_r[res_slot] <= 1'b0;
        ready_r[res_slot] <= 1'b0;
        last_slot_r       <= res_slot;
        cur_slot_r        <= res_slot;
        cur_valid_r       <= 1'b1;
        disp_r            <= DISP_RESUME;
        dslot_r           <= res_slot;
      end else if (free_slot_any && task_any) begin
        last_task_r            <= task_pick;
        active_r[task_pick]    <= 1'b1;
        queued_r[task_pick]    <= 1'b0;
        parked_r[free_slot]    <= 1'b1;
        armed_r[free_slot]     <= 1'b0;
        ready_r[free_slot]     <= 1'b0;
        slot_task_r[free_slot] <= task_pick;
        cur_slot_r             <= free_slot;
        cur_valid_r            <= 1'b1;
        disp_r                 <= DISP_START;
        dslot_r                <= free_slot;
      end
    end
  end

  assign out_ok            = ok_r;
  assign out_new_task_id   = new_id_r;
  assign out_dispatch      = disp_r;
  assign out_dispatch_slot = dslot_r;
  assign out_running_task  = cur_valid_r ? slot_task_r[cur_slot_r] : '0;
  assign out_running_valid = cur_valid_r;

endmodule

// File: rtl/core/cooperative_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_unit: cooperative task scheduler top level
// Pulse start with a request while busy is low. Requests that do not run the
// scheduler are latched and then executed; wait, finish and schedule
// requests that go on to the scheduler add a final step that commits
// the round-robin slot and task searches. The result appears for exactly one
// cycle with out_valid high and cannot be held off; the next item can be
// started in the cycle the result shows.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [5:0] in_task_id,
  input  logic [2:0] in_slot_index,
  output logic       out_valid,
  output logic       out_ok,
  output logic [5:0] out_new_task_id,
  output logic [1:0] out_dispatch,
  output logic [2:0] out_dispatch_slot,
  output logic [5:0] out_running_task,
  output logic       out_running_valid
);
  import cts_pkg::*;

  cts_cmd_t cmd;
  cts_sts_t sts;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  cts_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_task_id        (in_task_id),
    .in_slot_index     (in_slot_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_ok            (out_ok),
    .out_new_task_id   (out_new_task_id),
    .out_dispatch      (out_dispatch),
    .out_dispatch_slot (out_dispatch_slot),
    .out_running_task  (out_running_task),
    .out_running_valid (out_running_valid)
  );

endmodule
